/* rtl/core/rpn_pkg.sv */
// ----------------------------------------------------------------------------
// rpn_pkg
// Shared codes, field widths and sequencer states for the stack evaluator.
// ----------------------------------------------------------------------------
package rpn_pkg;

  // token field widths
  localparam int unsigned FUNC_W    = 3;
  localparam int unsigned OPND_W    = 32;
  localparam int unsigned TOP_W     = 32;
  localparam int unsigned LEVEL_W   = 5;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned ERR_W     = 2;

  // operator codes
  localparam logic [FUNC_W-1:0] FUNC_PUSH = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_SUB  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_MUL  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_DIV  = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_UNDER = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DIVZ  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 3'd4;

  // configuration register map
  localparam int unsigned   CFG_DATA_W = 32;
  localparam int unsigned   CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] ADDR_OPERAND_ORDER = 2'd0;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_LOAD,
    S_EXEC,
    S_ABSL,
    S_ABSR,
    S_MUL,
    S_DIV,
    S_SIGN,
    S_OUT
  } state_t;

endpackage

/* rtl/core/rpn_chan_if.sv */
// ----------------------------------------------------------------------------
// rpn_chan_if
// Valid/ready channels for the evaluator: token in, result out.
// ----------------------------------------------------------------------------
interface rpn_tok_if;
  logic                                valid;
  logic                                ready;
  logic        [rpn_pkg::FUNC_W-1:0]   func;
  logic signed [rpn_pkg::OPND_W-1:0]   operand_value;
  logic                                last_token;

  modport source (output valid, output func, output operand_value, output last_token,
                  input ready);
  modport sink   (input valid, input func, input operand_value, input last_token,
                  output ready);
endinterface

interface rpn_res_if;
  logic                                valid;
  logic                                ready;
  logic signed [rpn_pkg::TOP_W-1:0]    top_value;
  logic        [rpn_pkg::LEVEL_W-1:0]  stack_level;
  logic        [rpn_pkg::STATUS_W-1:0] status;
  logic                                done_res;

  modport source (output valid, output top_value, output stack_level, output status,
                  output done_res, input ready);
  modport sink   (input valid, input top_value, input stack_level, input status,
                  input done_res, output ready);
endinterface

/* rtl/core/rpn_stack_evaluator.sv */
// ----------------------------------------------------------------------------
// rpn_stack_evaluator
// Token-at-a-time stack calculator with one shared adder and a bit-serial
// multiply/divide sequence.
// ----------------------------------------------------------------------------
// One token is taken at a time and gives exactly one result transaction.
// A push or a no-op goes from decode straight to the result register; add and
// subtract pass through load and execute; multiply and divide continue from
// execute into a bit-serial sequence set by the single shared adder, which
// retires one bit of the product or quotient per cycle.
// The result sits in an output register, so the next token can be accepted
// while it waits. The top of stack lives in a register and the entries below
// it in a one-read, one-write memory; its contents are not cleared at reset.
// operand_order (byte address 0) must only be written while the block is idle.
module rpn_stack_evaluator #(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst_n,
  rpn_tok_if.sink                            in_chan,
  rpn_res_if.source                          out_chan,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rpn_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [rpn_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [rpn_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready
);

  localparam int unsigned VW = VALUE_WIDTH;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IW = $clog2(STACK_DEPTH);
  localparam int unsigned NW = $clog2(VW);

  rpn_pkg::state_t state_r, state_nxt;

  logic                            order_r;
  logic [CW-1:0]                   count_r;
  logic [rpn_pkg::ERR_W-1:0]       err_code_r;
  logic                            err_seen_r;

  logic [rpn_pkg::FUNC_W-1:0]      func_r;
  logic                            last_r;
  logic [VW-1:0]                   opv_r;
  logic [VW-1:0]                   top_r;
  logic [VW-1:0]                   lhs_r;
  logic [VW-1:0]                   rhs_r;
  logic [VW-1:0]                   rem_r;
  logic [NW-1:0]                   iter_r;
  logic                            negq_r;

  logic [VW-1:0]                   stack_mem [STACK_DEPTH];
  logic [VW-1:0]                   mem_rd_r;

  logic                            out_valid_r;
  logic [rpn_pkg::TOP_W-1:0]       out_top_r;
  logic [rpn_pkg::LEVEL_W-1:0]     out_level_r;
  logic [rpn_pkg::STATUS_W-1:0]    out_status_r;
  logic                            out_done_r;

  logic signed [VW+31:0]           opnd_ext;
  logic [VW+31:0]                  top_ext;
  logic [CW+4:0]                   level_ext;
  logic [CW-1:0]                   cnt_m1;
  logic [CW-1:0]                   cnt_m2;
  logic                            stack_full;
  logic                            stack_short;
  logic                            mem_we;
  logic                            in_fire;
  logic                            cfg_wr;
  logic                            out_load;

  logic [VW:0]                     add_a;
  logic [VW:0]                     add_b;
  logic                            add_cin;
  logic [VW+1:0]                   sum;
  logic                            div_fit;

  // --------------------------------------------------------------------------
  // configuration port
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    if (paddr == rpn_pkg::ADDR_OPERAND_ORDER) begin
      prdata[0] = order_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= 1'b0;
    end else if (cfg_wr && paddr == rpn_pkg::ADDR_OPERAND_ORDER) begin
      order_r <= pwdata[0];
    end
  end

  // --------------------------------------------------------------------------
  // handshakes and helpers
  // --------------------------------------------------------------------------
  assign in_chan.ready = rst_n && (state_r == rpn_pkg::S_IDLE);
  assign in_fire       = in_chan.valid && in_chan.ready;

  assign opnd_ext    = (VW+32)'(in_chan.operand_value);
  assign cnt_m1      = count_r - CW'(1);
  assign cnt_m2      = count_r - CW'(2);
  assign stack_full  = (count_r >= CW'(STACK_DEPTH));
  assign stack_short = (count_r < CW'(2));

  assign top_ext   = (VW+32)'(top_r);
  assign level_ext = (CW+5)'(count_r);

  assign out_load = (state_r == rpn_pkg::S_OUT) && (!out_valid_r || out_chan.ready);

  assign mem_we = (state_r == rpn_pkg::S_DECODE) && !err_seen_r &&
                  (func_r == rpn_pkg::FUNC_PUSH) && !stack_full && (count_r != '0);

  // --------------------------------------------------------------------------
  // shared adder: add/sub, negate, multiply step, divide trial subtract
  // --------------------------------------------------------------------------
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_cin = 1'b0;
    unique case (state_r)
      rpn_pkg::S_EXEC: begin
        add_a = {1'b0, lhs_r};
        if (func_r == rpn_pkg::FUNC_SUB) begin
          add_b   = ~{1'b0, rhs_r};
          add_cin = 1'b1;
        end else begin
          add_b = {1'b0, rhs_r};
        end
      end
      rpn_pkg::S_ABSL, rpn_pkg::S_SIGN: begin
        add_b   = ~{1'b0, lhs_r};
        add_cin = 1'b1;
      end
      rpn_pkg::S_ABSR: begin
        add_b   = ~{1'b0, rhs_r};
        add_cin = 1'b1;
      end
      rpn_pkg::S_MUL: begin
        add_a = {1'b0, rem_r};
        add_b = rhs_r[0] ? {1'b0, lhs_r} : '0;
      end
      rpn_pkg::S_DIV: begin
        add_a   = {rem_r, lhs_r[VW-1]};
        add_b   = ~{1'b0, rhs_r};
        add_cin = 1'b1;
      end
      default: begin
        add_a   = '0;
        add_b   = '0;
        add_cin = 1'b0;
      end
    endcase
  end

  assign sum     = {1'b0, add_a} + {1'b0, add_b} + (VW+2)'(add_cin);
  assign div_fit = sum[VW+1];

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rpn_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rpn_pkg::S_IDLE: begin
        if (in_fire) state_nxt = rpn_pkg::S_DECODE;
      end
      rpn_pkg::S_DECODE: begin
        if (!err_seen_r && func_r != rpn_pkg::FUNC_PUSH &&
            func_r <= rpn_pkg::FUNC_DIV && !stack_short) begin
          state_nxt = rpn_pkg::S_LOAD;
        end else begin
          state_nxt = rpn_pkg::S_OUT;
        end
      end
      rpn_pkg::S_LOAD: state_nxt = rpn_pkg::S_EXEC;
      rpn_pkg::S_EXEC: begin
        if (func_r == rpn_pkg::FUNC_MUL) begin
          state_nxt = rpn_pkg::S_MUL;
        end else if (func_r == rpn_pkg::FUNC_DIV && rhs_r != '0) begin
          state_nxt = rpn_pkg::S_ABSL;
        end else begin
          state_nxt = rpn_pkg::S_OUT;
        end
      end
      rpn_pkg::S_ABSL: state_nxt = rpn_pkg::S_ABSR;
      rpn_pkg::S_ABSR: state_nxt = rpn_pkg::S_DIV;
      rpn_pkg::S_MUL: begin
        if (iter_r == '0) state_nxt = rpn_pkg::S_OUT;
      end
      rpn_pkg::S_DIV: begin
        if (iter_r == '0) state_nxt = rpn_pkg::S_SIGN;
      end
      rpn_pkg::S_SIGN: state_nxt = rpn_pkg::S_OUT;
      rpn_pkg::S_OUT: begin
        if (out_load) state_nxt = rpn_pkg::S_IDLE;
      end
      default: state_nxt = rpn_pkg::S_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // stack memory: entries below the top of stack
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[cnt_m1[IW-1:0]] <= top_r;
    end
    mem_rd_r <= stack_mem[cnt_m2[IW-1:0]];
  end

  // --------------------------------------------------------------------------
  // control state: count and sticky error
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      err_code_r <= '0;
      err_seen_r <= 1'b0;
    end else begin
      case (state_r)
        rpn_pkg::S_DECODE: begin
          if (!err_seen_r) begin
            if (func_r == rpn_pkg::FUNC_PUSH) begin
              if (stack_full) begin
                err_code_r <= rpn_pkg::ST_FULL[rpn_pkg::ERR_W-1:0];
                err_seen_r <= 1'b1;
              end else begin
                count_r <= count_r + CW'(1);
              end
            end else if (func_r <= rpn_pkg::FUNC_DIV && stack_short) begin
              err_code_r <= rpn_pkg::ST_UNDER[rpn_pkg::ERR_W-1:0];
              err_seen_r <= 1'b1;
            end
          end
        end
        rpn_pkg::S_EXEC: begin
          if (func_r == rpn_pkg::FUNC_ADD || func_r == rpn_pkg::FUNC_SUB) begin
            count_r <= cnt_m1;
          end else if (func_r == rpn_pkg::FUNC_DIV && rhs_r == '0) begin
            err_code_r <= rpn_pkg::ST_DIVZ[rpn_pkg::ERR_W-1:0];
            err_seen_r <= 1'b1;
          end
        end
        rpn_pkg::S_MUL: begin
          if (iter_r == '0) count_r <= cnt_m1;
        end
        rpn_pkg::S_SIGN: count_r <= cnt_m1;
        rpn_pkg::S_OUT: begin
          // last token closes the expression once its result is registered
          if (out_load && last_r) begin
            count_r    <= '0;
            err_code_r <= '0;
            err_seen_r <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // datapath registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_fire) begin
      func_r <= in_chan.func;
      last_r <= in_chan.last_token;
      opv_r  <= opnd_ext[VW-1:0];
    end
    case (state_r)
      rpn_pkg::S_DECODE: begin
        if (!err_seen_r && func_r == rpn_pkg::FUNC_PUSH && !stack_full) begin
          top_r <= opv_r;
        end
      end
      rpn_pkg::S_LOAD: begin
        if (order_r) begin
          lhs_r <= top_r;
          rhs_r <= mem_rd_r;
        end else begin
          lhs_r <= mem_rd_r;
          rhs_r <= top_r;
        end
      end
      rpn_pkg::S_EXEC: begin
        if (func_r == rpn_pkg::FUNC_ADD || func_r == rpn_pkg::FUNC_SUB) begin
          top_r <= sum[VW-1:0];
        end
        rem_r  <= '0;
        iter_r <= NW'(VW - 1);
        negq_r <= lhs_r[VW-1] ^ rhs_r[VW-1];
      end
      rpn_pkg::S_ABSL: begin
        if (lhs_r[VW-1]) lhs_r <= sum[VW-1:0];
      end
      rpn_pkg::S_ABSR: begin
        if (rhs_r[VW-1]) rhs_r <= sum[VW-1:0];
      end
      rpn_pkg::S_MUL: begin
        // shift-and-add, low VALUE_WIDTH bits of the product only
        rem_r  <= sum[VW-1:0];
        lhs_r  <= {lhs_r[VW-2:0], 1'b0};
        rhs_r  <= {1'b0, rhs_r[VW-1:1]};
        iter_r <= iter_r - NW'(1);
        if (iter_r == '0) top_r <= sum[VW-1:0];
      end
      rpn_pkg::S_DIV: begin
        // restoring divide; quotient bits shift into lhs as the dividend leaves
        if (div_fit) begin
          rem_r <= sum[VW-1:0];
        end else begin
          rem_r <= {rem_r[VW-2:0], lhs_r[VW-1]};
        end
        lhs_r  <= {lhs_r[VW-2:0], div_fit};
        iter_r <= iter_r - NW'(1);
      end
      rpn_pkg::S_SIGN: begin
        top_r <= negq_r ? sum[VW-1:0] : lhs_r;
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_top_r   <= (count_r != '0) ? top_ext[rpn_pkg::TOP_W-1:0] : '0;
      out_level_r <= level_ext[rpn_pkg::LEVEL_W-1:0];
      out_done_r  <= last_r;
      if (err_seen_r) begin
        out_status_r <= rpn_pkg::STATUS_W'(err_code_r);
      end else if (last_r && count_r == '0) begin
        out_status_r <= rpn_pkg::ST_EMPTY;
      end else begin
        out_status_r <= rpn_pkg::ST_OK;
      end
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.top_value   = out_top_r;
  assign out_chan.stack_level = out_level_r;
  assign out_chan.status      = out_status_r;
  assign out_chan.done_res    = out_done_r;

endmodule
